// ----- hw/rtl/tli_pkg.sv -----
// tli_pkg: shared widths, status codes and the queued command type for the
// table linear interpolator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tli_pkg;

  localparam int unsigned XW         = 32;   // Q16.16 coordinate width
  localparam int unsigned SLOT_W     = 8;    // point_index width
  localparam int unsigned CNT_W      = 9;    // points_in_use width
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned DEF_POINTS = 256;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_INTERP   = 2'd0;
  localparam logic [STAT_W-1:0] ST_CLAMP_LO = 2'd1;
  localparam logic [STAT_W-1:0] ST_CLAMP_HI = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  // one command between front and back; for a query, a_val holds query_x
  typedef struct packed {
    logic              is_query;
    logic [SLOT_W-1:0] slot;
    logic [XW-1:0]     a_val;
    logic [XW-1:0]     b_val;
  } cmd_t;

  typedef struct packed {
    logic [XW-1:0]     value;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tli_if.sv -----
// tli_in_if / tli_out_if: valid-ready channels for items and results.
// Depends on tli_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tli_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [tli_pkg::SLOT_W-1:0]  point_index;
  logic [tli_pkg::XW-1:0]      point_x;
  logic [tli_pkg::XW-1:0]      point_y;
  logic [tli_pkg::XW-1:0]      query_x;

  modport source (output valid, operation, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink   (input valid, operation, point_index, point_x, point_y, query_x,
                  output ready);
endinterface

interface tli_out_if;
  logic                        valid;
  logic                        ready;
  logic [tli_pkg::XW-1:0]      curve_value;
  logic [tli_pkg::STAT_W-1:0]  result_status;

  modport source (output valid, curve_value, result_status, input ready);
  modport sink   (input valid, curve_value, result_status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tli_ram.sv -----
// tli_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tli_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tli_front.sv -----
// tli_front: accepts items, drops writes to slots outside the table and
// queues the rest for the back end. Depends on tli_pkg and tli_in_if.
`timescale 1ns / 1ps
`default_nettype none

module tli_front #(
  parameter int unsigned POINTS = tli_pkg::DEF_POINTS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tli_in_if.sink             item_i,
  output logic               cmd_valid_o,
  output tli_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_pop_i
);

  localparam int unsigned QD = 2;

  tli_pkg::cmd_t buf_q [QD];
  logic [1:0]    count_q, count_d;
  logic          wp_q, rp_q;
  logic          accept, push, in_range;
  tli_pkg::cmd_t cmd_in;

  assign item_i.ready = (count_q != 2'(QD));
  assign accept       = item_i.valid & item_i.ready;
  assign in_range     = (32'(item_i.point_index) < 32'(POINTS));
  assign push         = accept & ((item_i.operation == tli_pkg::OP_QUERY) | in_range);

  always_comb begin
    cmd_in.is_query = (item_i.operation == tli_pkg::OP_QUERY);
    cmd_in.slot     = item_i.point_index;
    cmd_in.a_val    = cmd_in.is_query ? item_i.query_x : item_i.point_x;
    cmd_in.b_val    = item_i.point_y;
  end

  always_comb begin
    unique case ({push, cmd_pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (cmd_pop_i) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= cmd_in;
    end
  end

  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = buf_q[rp_q];

endmodule

`default_nettype wire

// ----- hw/rtl/tli_back.sv -----
// tli_back: executes queued commands: table writes, linear search, multiply
// and a radix-2 divide. Holds the breakpoint RAM. Depends on tli_pkg, tli_ram.
`timescale 1ns / 1ps
`default_nettype none

module tli_back #(
  parameter int unsigned POINTS = tli_pkg::DEF_POINTS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [tli_pkg::CNT_W-1:0]  points_in_use_i,
  input  wire logic                       cmd_valid_i,
  input  wire tli_pkg::cmd_t              cmd_i,
  output logic                            cmd_pop_o,
  input  wire logic                       res_free_i,
  output logic                            res_load_o,
  output tli_pkg::res_t                   res_o
);

  localparam int unsigned XW  = tli_pkg::XW;
  localparam int unsigned AW  = $clog2(POINTS);
  localparam int unsigned UW  = ($clog2(POINTS + 1) > tli_pkg::CNT_W) ?
                                $clog2(POINTS + 1) : tli_pkg::CNT_W;
  localparam int unsigned DCW = $clog2(XW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]              state_q;
  logic [UW-1:0]           used_q, ra_q, k_q;
  logic [UW-1:0]           used;
  logic [DCW-1:0]          cnt_q;
  logic [XW-1:0]           qx_q, px_q, py_q, y0_q;
  logic [XW-1:0]           rise_q, along_q, span_q;
  logic [XW-1:0]           rem_q, dq_q, value_q;
  logic [tli_pkg::STAT_W-1:0] status_q;
  logic                    neg_q, interp_q;

  logic                    ram_we;
  logic [AW-1:0]           ram_raddr;
  logic [2*XW-1:0]         ram_rdata;
  logic [XW-1:0]           rx, ry;
  logic [2*XW-1:0]         prod;
  logic [XW:0]             trial;
  logic                    qbit;

  assign used = (UW'(points_in_use_i) > UW'(POINTS)) ? UW'(POINTS) : UW'(points_in_use_i);

  assign cmd_pop_o = (state_q == S_IDLE) & cmd_valid_i;
  assign ram_we    = cmd_pop_o & ~cmd_i.is_query;
  assign ram_raddr = (state_q == S_IDLE) ? '0 : ra_q[AW-1:0];

  tli_ram #(
    .WIDTH (2 * XW),
    .DEPTH (POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(cmd_i.slot)),
    .wdata_i ({cmd_i.a_val, cmd_i.b_val}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rx   = ram_rdata[2*XW-1:XW];
  assign ry   = ram_rdata[XW-1:0];
  assign prod = 64'(rise_q) * 64'(along_q);

  // restoring divide step: remainder stays below the span
  assign trial = {rem_q, dq_q[XW-1]};
  assign qbit  = (trial >= {1'b0, span_q});

  always_comb begin
    res_load_o   = (state_q == S_DONE) & res_free_i;
    res_o.status = status_q;
    if (interp_q) begin
      res_o.value = neg_q ? (y0_q - dq_q) : (y0_q + dq_q);
    end else begin
      res_o.value = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_pop_o && cmd_i.is_query) begin
            state_q <= (used == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rx >= qx_q) begin
            state_q <= (k_q == '0) ? S_DONE : S_MUL;
          end else if (k_q == used_q - UW'(1)) begin
            state_q <= S_DONE;
          end
        end
        S_MUL: state_q <= S_DIV;
        S_DIV: begin
          if (cnt_q == DCW'(XW - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        qx_q     <= cmd_i.a_val;
        used_q   <= used;
        ra_q     <= UW'(1);
        k_q      <= '0;
        value_q  <= '0;
        status_q <= tli_pkg::ST_EMPTY;
        interp_q <= 1'b0;
      end
      S_SCAN: begin
        ra_q <= ra_q + UW'(1);
        k_q  <= k_q + UW'(1);
        px_q <= rx;
        py_q <= ry;
        if (rx >= qx_q) begin
          if (k_q == '0) begin
            value_q  <= ry;
            status_q <= tli_pkg::ST_CLAMP_LO;
          end else begin
            y0_q     <= py_q;
            neg_q    <= (ry < py_q);
            rise_q   <= (ry < py_q) ? (py_q - ry) : (ry - py_q);
            along_q  <= qx_q - px_q;
            span_q   <= rx - px_q;
            status_q <= tli_pkg::ST_INTERP;
            interp_q <= 1'b1;
          end
        end else begin
          value_q  <= ry;
          status_q <= tli_pkg::ST_CLAMP_HI;
        end
      end
      S_MUL: begin
        rem_q <= prod[2*XW-1:XW];
        dq_q  <= prod[XW-1:0];
        cnt_q <= '0;
      end
      S_DIV: begin
        rem_q <= qbit ? XW'(trial - {1'b0, span_q}) : trial[XW-1:0];
        dq_q  <= {dq_q[XW-2:0], qbit};
        cnt_q <= cnt_q + DCW'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/table_linear_interpolator_unit.sv -----
// table_linear_interpolator_unit: top level, config register, output register
// and assertions. Depends on tli_pkg, tli_if, tli_front, tli_back.
//
// Usage: item_i carries transactions of two kinds. A write (operation 0)
// stores (point_x, point_y) into slot point_index; writes to slots at or
// beyond POINTS are dropped. A query (operation 1) returns one transaction on
// result_o: the curve interpolated at query_x, or a clamped end value, or zero
// with the empty status when points_in_use is zero. cfg_we_i/cfg_wdata_i set
// points_in_use; write it only while the block is idle.
// A write is executed by the back end without leaving its idle state. A query
// scans breakpoints, one per cycle through the table RAM read port, until it
// clamps or finds its segment; to interpolate, one multiply and a 32-step
// shift-subtract divider follow. Queries are run one at a time; a 2-entry
// command queue lets items be taken while one executes.
// Reset clears points_in_use and all control state; the table contents are
// undefined until written. When the receiver stalls, one finished result waits
// in the output register, the next one waits in the executor, and the queue
// fills before item_i.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module table_linear_interpolator_unit #(
  parameter int unsigned POINTS = tli_pkg::DEF_POINTS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  tli_in_if.sink                          item_i,
  tli_out_if.source                       result_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [tli_pkg::CNT_W-1:0]  cfg_wdata_i
);

  logic [tli_pkg::CNT_W-1:0] pts_q;
  logic                      cmd_valid, cmd_pop;
  tli_pkg::cmd_t             cmd;
  logic                      res_free, res_load;
  tli_pkg::res_t             res;
  logic                      out_vld_q;
  tli_pkg::res_t             out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q <= '0;
    end else if (cfg_we_i) begin
      pts_q <= cfg_wdata_i;
    end
  end

  tli_front #(
    .POINTS (POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  tli_back #(
    .POINTS (POINTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .points_in_use_i (pts_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .res_free_i      (res_free),
    .res_load_o      (res_load),
    .res_o           (res)
  );

  assign res_free = ~out_vld_q | result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_load) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.curve_value   = out_q.value;
  assign result_o.result_status = out_q.status;

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> res_free)
    else $error("result loaded while output register busy");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.result_status == tli_pkg::ST_EMPTY)
      |-> (result_o.curve_value == '0))
    else $error("empty-table result is not zero");

  // a result is loaded only for a query that left the queue earlier
  a_load_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !cmd_pop)
    else $error("result loaded while executor took a command");

endmodule

`default_nettype wire

// ----- sim/tb_table_linear_interpolator_unit.sv -----
// tb_table_linear_interpolator_unit: self-checking bench for the breakpoint table
// interpolator; predicts every query result in-bench and checks results in order.
// Depends on tli_pkg, tli_if and the table_linear_interpolator_unit RTL.
`timescale 1ns / 1ps

module tb_table_linear_interpolator_unit;
  import tli_pkg::*;

  localparam int unsigned ITEMS_TARGET = 1950;

  typedef enum int unsigned {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  tli_in_if  item_bus ();
  tli_out_if res_bus ();

  table_linear_interpolator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_bus),
    .result_o    (res_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // in-bench copy of the breakpoint table and the point count
  logic [XW-1:0]    knot_x [DEF_POINTS];
  logic [XW-1:0]    knot_y [DEF_POINTS];
  logic [CNT_W-1:0] pts_cfg;
  res_t             curve_q [$];

  int unsigned n_sent;
  int unsigned n_fail;
  int unsigned burst_left;

  rx_mode_e    rx_mode;
  int unsigned rx_span;
  int unsigned rx_hold;
  int unsigned rx_phase;
  logic        rx_level;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic res_t predict_curve(input logic [XW-1:0] q);
    int unsigned used;
    int unsigned i;
    logic [63:0] span;
    logic [63:0] along;
    logic [63:0] rise;
    logic [63:0] delta;
    res_t r;
    used = (pts_cfg > DEF_POINTS) ? DEF_POINTS : pts_cfg;
    r.value = '0;
    r.status = ST_EMPTY;
    if (used != 0) begin
      i = 0;
      while (i < used && knot_x[i] < q) i++;
      if (i == 0) begin
        r.value = knot_y[0];
        r.status = ST_CLAMP_LO;
      end else if (i == used) begin
        r.value = knot_y[used-1];
        r.status = ST_CLAMP_HI;
      end else begin
        span  = {32'b0, knot_x[i]} - {32'b0, knot_x[i-1]};
        along = {32'b0, q} - {32'b0, knot_x[i-1]};
        if (knot_y[i] >= knot_y[i-1]) rise = {32'b0, knot_y[i]} - {32'b0, knot_y[i-1]};
        else rise = {32'b0, knot_y[i-1]} - {32'b0, knot_y[i]};
        // exact quotient, truncated; product fits in 64 bits
        delta = (rise * along) / span;
        if (knot_y[i] >= knot_y[i-1]) r.value = knot_y[i-1] + delta[XW-1:0];
        else r.value = knot_y[i-1] - delta[XW-1:0];
        r.status = ST_INTERP;
      end
    end
    return r;
  endfunction

  // one transaction on the item channel, with burst/gap pacing
  task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                           input logic [XW-1:0] px, input logic [XW-1:0] py,
                           input logic [XW-1:0] qx);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    item_bus.valid       <= 1'b1;
    item_bus.operation   <= op;
    item_bus.point_index <= slot;
    item_bus.point_x     <= px;
    item_bus.point_y     <= py;
    item_bus.query_x     <= qx;
    do @(posedge clk_i); while (!item_bus.ready);
    if (op == OP_WRITE) begin
      knot_x[slot] = px;
      knot_y[slot] = py;
    end else begin
      curve_q = {curve_q, predict_curve(qx)};
    end
    n_sent++;
  endtask

  task automatic put_knot(input logic [SLOT_W-1:0] slot, input logic [XW-1:0] x,
                          input logic [XW-1:0] y);
    send_item(OP_WRITE, slot, x, y, $urandom());
  endtask

  task automatic ask_curve(input logic [XW-1:0] q);
    send_item(OP_QUERY, SLOT_W'($urandom()), $urandom(), $urandom(), q);
  endtask

  // drop valid, drain all results, then let trailing writes retire
  task automatic wait_idle();
    @(negedge clk_i);
    item_bus.valid <= 1'b0;
    while (curve_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_points(input logic [CNT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    pts_cfg = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // writes slots 0..n-1, mostly ascending with steps of varied scale
  task automatic fill_table(input int unsigned n);
    int unsigned kind;
    longint unsigned x;
    longint unsigned room;
    longint unsigned cap;
    logic [XW-1:0] y;
    kind = $urandom_range(0, 9);
    x = (kind < 3) ? $urandom_range(0, 64) : $urandom_range(0, 32'h00FF_FFFF);
    y = $urandom();
    for (int unsigned i = 0; i < n; i++) begin
      if (kind == 9) begin
        x = $urandom();
      end else if (i != 0) begin
        room = (64'hFFFF_FFFF - x) / (n - i);
        cap = (kind < 3) ? 16 : (kind < 7) ? 64'h0004_0000 : room;
        if (cap > room) cap = room;
        x = x + $urandom_range(32'(cap), 0);
      end
      case ($urandom_range(0, 3))
        0: y = y + $urandom_range(0, 255) - 128;
        1: y = y;
        default: y = $urandom();
      endcase
      put_knot(i[SLOT_W-1:0], x[XW-1:0], y);
    end
  endtask

  function automatic logic [XW-1:0] pick_query(input int unsigned n);
    int unsigned k;
    k = (n > 1) ? $urandom_range(1, n - 1) : 0;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      2: return knot_x[k];
      3: return knot_x[k] + 1;
      4: return knot_x[k] - 1;
      default: return (n > 1) ? $urandom_range(knot_x[k], knot_x[k-1]) : $urandom();
    endcase
  endfunction

  task automatic test_empty_table();
    set_points(0);
    ask_curve(32'h0);
    ask_curve(32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_directed_curve();
    put_knot(0, 32'h0001_0000, 32'h0000_0000);
    put_knot(1, 32'h0002_8000, 32'hFFFF_FFFF);
    put_knot(2, 32'h8000_0000, 32'h1234_5678);
    put_knot(3, 32'hFFFF_FFFF, 32'h1234_5678);
    wait_idle();
    set_points(4);
    ask_curve(32'h0000_0000);  // below first point
    ask_curve(32'h0001_0000);  // exactly at first point
    ask_curve(32'h0001_0001);
    ask_curve(32'h0002_0000);  // rising segment, full-scale rise
    ask_curve(32'h0002_8000);  // on an interior breakpoint
    ask_curve(32'h4000_0000);  // falling segment
    ask_curve(32'hFFFF_FFFF);  // flat last segment at max x
    wait_idle();
    set_points(1);
    ask_curve(32'h0000_0000);
    ask_curve(32'h0001_0000);
    ask_curve(32'h0001_0001);  // single point, past it
    wait_idle();
  endtask

  task automatic test_full_table();
    set_points(CNT_W'(DEF_POINTS));
    fill_table(DEF_POINTS);
    repeat (60) ask_curve(pick_query(DEF_POINTS));
    wait_idle();
    // count above the table size searches the whole table
    set_points('1);
    repeat (15) ask_curve(pick_query(DEF_POINTS));
    wait_idle();
  endtask

  task automatic test_random_curves();
    int unsigned r;
    int unsigned n;
    int unsigned n_q;
    while (n_sent < ITEMS_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(2, 8);
      else if (r < 90) n = $urandom_range(9, 32);
      else if (r < 97) n = 1;
      else n = $urandom_range(33, 128);
      // every slot holds data by now, so any count is legal
      if ($urandom_range(0, 19) == 0) set_points(CNT_W'($urandom_range(0, 511)));
      else set_points(CNT_W'(n));
      fill_table(n);
      n_q = $urandom_range(10, 40);
      repeat (n_q) begin
        if ($urandom_range(0, 99) < 8) put_knot(SLOT_W'($urandom()), $urandom(), $urandom());
        else ask_curve(pick_query(n));
      end
      wait_idle();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (curve_q.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d", $time,
                 res_bus.curve_value, res_bus.result_status);
        n_fail++;
      end else begin
        if (res_bus.curve_value !== curve_q[0].value) begin
          $display("%0t: curve_value expected %h, got %h", $time,
                   curve_q[0].value, res_bus.curve_value);
          n_fail++;
        end
        if (res_bus.result_status !== curve_q[0].status) begin
          $display("%0t: result_status expected %0d, got %0d", $time,
                   curve_q[0].status, res_bus.result_status);
          n_fail++;
        end
        void'(curve_q.pop_front());
      end
    end
  end

  // receiver back-pressure, switching between patterns
  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_span = $urandom_range(50, 400);
    end
    rx_span--;
    case (rx_mode)
      RX_OPEN: res_bus.ready <= 1'b1;
      RX_RANDOM: res_bus.ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: begin
        rx_phase++;
        res_bus.ready <= (rx_phase % 3 == 0);
      end
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 25);
          rx_level = ~rx_level;
        end
        rx_hold--;
        res_bus.ready <= rx_level;
      end
    endcase
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    item_bus.valid = 1'b0;
    item_bus.operation = OP_WRITE;
    item_bus.point_index = '0;
    item_bus.point_x = '0;
    item_bus.point_y = '0;
    item_bus.query_x = '0;
    res_bus.ready = 1'b1;
    pts_cfg = '0;
    n_sent = 0;
    n_fail = 0;
    burst_left = 0;
    rx_mode = RX_OPEN;
    rx_span = 100;
    rx_hold = 0;
    rx_phase = 0;
    rx_level = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_directed_curve();
    test_full_table();
    test_random_curves();

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
